@@ src/sha1_message_hasher_assert.svh @@
// Assertion macros for the SHA-1 message hasher checker.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef SHA1_MESSAGE_HASHER_ASSERT_SVH
`define SHA1_MESSAGE_HASHER_ASSERT_SVH

// Condition must never hold outside reset
`define SHA1MH_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

// Trigger implies the consequence on the next clock
`define SHA1MH_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

`endif

@@ src/sha1mh_pkg.sv @@
// Shared types, constants and round functions of the SHA-1 message hasher.
// No dependencies; used by all RTL modules of the block.
`timescale 1ns / 1ps

package sha1mh_pkg;

    typedef logic [31:0]      t_word;
    typedef logic [3:0][7:0]  t_word_bytes;
    typedef logic [4:0][31:0] t_hash_state;

    // Controls from the sequencer to the round core
    typedef struct packed {
        logic load_w;
        logic load_h;
        logic step;
    } t_core_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_FETCH,
        ST_SHOW
    } t_state;

    // How the bytes of the block being loaded are formed
    typedef enum logic [1:0] {
        MODE_FULL,
        MODE_TAIL,
        MODE_LENGTH
    } t_mode;

    localparam t_word K_ROUND0 = 32'h5A827999;
    localparam t_word K_ROUND1 = 32'h6ED9EBA1;
    localparam t_word K_ROUND2 = 32'h8F1BBCDC;
    localparam t_word K_ROUND3 = 32'hCA62C1D6;

    // Element 0 is H0
    localparam t_hash_state H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [6:0] LAST_ROUND  = 7'd79;
    localparam logic [6:0] LOAD_END    = 7'd16;
    localparam logic [6:0] CHAIN_WORDS = 7'd5;
    localparam logic [6:0] LAST_DIGEST = 7'd19;
    localparam logic [5:0] LAST_FILL   = 6'd63;
    localparam logic [5:0] LEN_START   = 6'd56;

    function automatic t_word round_f(input logic [6:0] rnd, input t_word b,
                                      input t_word c, input t_word d);
        t_word f;
        if (rnd < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (rnd < 7'd40) begin
            f = b ^ c ^ d;
        end else if (rnd < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic t_word round_k(input logic [6:0] rnd);
        t_word k;
        if (rnd < 7'd20) begin
            k = K_ROUND0;
        end else if (rnd < 7'd40) begin
            k = K_ROUND1;
        end else if (rnd < 7'd60) begin
            k = K_ROUND2;
        end else begin
            k = K_ROUND3;
        end
        return k;
    endfunction

endpackage

@@ src/sha1_message_hasher.sv @@
// SHA-1 message hasher top level: sequencer, padding and digest output.
// Uses sha1mh_pkg, sha1mh_block_ram, sha1mh_chain_ram and sha1mh_round_core.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_command, i_data_byte
//  out     | output    | o_out_valid / i_out_ready | o_digest_byte, o_last_of_digest
//
// An append is taken while idle; the append that fills the block starts compression
// (buffer and chain reads, 80 rounds at one per cycle, then chain updates).
// A finish compresses one or two padded blocks, then gives each of the 20 digest
// bytes as a chain memory read followed by an offer that waits for i_out_ready.
// Output stalls hold the digest byte; no new request is taken until the digest is out.
// Reset is synchronous, active low; it clears the sequencer, counts and chain valid bits.
`timescale 1ns / 1ps

module sha1_message_hasher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_command,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_digest_byte,
    output logic       o_last_of_digest
);

    sha1mh_pkg::t_state r_state, n_state;
    sha1mh_pkg::t_mode  r_mode,  n_mode;
    logic [6:0]         r_cnt,   n_cnt;
    logic [5:0]         r_fill,  n_fill;
    logic [54:0]        r_blk,   n_blk;

    logic               w_accept;
    logic               w_bram_we, w_bram_re;
    sha1mh_pkg::t_word  w_bram_rd;
    logic               w_cram_we, w_cram_re, w_cram_clear;
    logic [2:0]         w_cram_wa, w_cram_ra;
    sha1mh_pkg::t_word  w_cram_wd, w_cram_rd;
    sha1mh_pkg::t_core_ctl   w_ctl;
    sha1mh_pkg::t_hash_state w_core_st;
    sha1mh_pkg::t_word_bytes w_pad_word;
    sha1mh_pkg::t_word_bytes w_mem_word;
    sha1mh_pkg::t_word_bytes w_out_word;
    logic [7:0][7:0]    w_total;
    logic [3:0]         w_widx;
    logic [2:0]         w_upd_idx;

    assign w_accept = i_in_valid && o_in_ready;

    sha1mh_block_ram u_block_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_bram_we),
        .i_wr_addr (r_fill[5:2]),
        .i_wr_lane (r_fill[1:0]),
        .i_wr_byte (i_data_byte),
        .i_rd_en   (w_bram_re),
        .i_rd_addr (r_cnt[3:0]),
        .o_rd_data (w_bram_rd)
    );

    sha1mh_chain_ram u_chain_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_cram_clear),
        .i_wr_en   (w_cram_we),
        .i_wr_addr (w_cram_wa),
        .i_wr_data (w_cram_wd),
        .i_rd_en   (w_cram_re),
        .i_rd_addr (w_cram_ra),
        .o_rd_data (w_cram_rd)
    );

    sha1mh_round_core u_round_core (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_rnd    (r_cnt),
        .i_w_word (w_pad_word),
        .i_h_word (w_cram_rd),
        .o_state  (w_core_st)
    );

    // Form padded block words: message bytes, end marker, zeros, bit length
    always_comb begin
        logic [5:0] p;
        logic [7:0] len_byte;
        w_total    = {r_blk, r_fill, 3'b000};
        w_mem_word = w_bram_rd;
        w_widx     = 4'(r_cnt - 7'd1);
        for (int j = 0; j < 4; j++) begin
            p        = {w_widx, 2'(j)};
            len_byte = w_total[~p[2:0]];
            case (r_mode)
                sha1mh_pkg::MODE_FULL: begin
                    w_pad_word[3-j] = w_mem_word[3-j];
                end
                sha1mh_pkg::MODE_TAIL: begin
                    if (p < r_fill) begin
                        w_pad_word[3-j] = w_mem_word[3-j];
                    end else if (p == r_fill) begin
                        w_pad_word[3-j] = sha1mh_pkg::PAD_MARK;
                    end else if (p >= sha1mh_pkg::LEN_START
                                 && r_fill < sha1mh_pkg::LEN_START) begin
                        w_pad_word[3-j] = len_byte;
                    end else begin
                        w_pad_word[3-j] = 8'h00;
                    end
                end
                sha1mh_pkg::MODE_LENGTH: begin
                    w_pad_word[3-j] = (p >= sha1mh_pkg::LEN_START) ? len_byte : 8'h00;
                end
                default: begin
                    w_pad_word[3-j] = 8'h00;
                end
            endcase
        end
    end

    // Chain update: add the working word to the chaining word just read
    assign w_upd_idx = 3'(r_cnt - 7'd1);
    assign w_cram_wa = w_upd_idx;
    assign w_cram_wd = w_cram_rd + w_core_st[w_upd_idx];

    // Select chain address: digest reads walk words by byte count
    assign w_cram_ra = (r_state == sha1mh_pkg::ST_FETCH || r_state == sha1mh_pkg::ST_SHOW)
                     ? r_cnt[4:2] : r_cnt[2:0];

    // Hold state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha1mh_pkg::ST_IDLE;
            r_mode  <= sha1mh_pkg::MODE_FULL;
            r_cnt   <= '0;
            r_fill  <= '0;
            r_blk   <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_cnt   <= n_cnt;
            r_fill  <= n_fill;
            r_blk   <= n_blk;
        end
    end

    // Sequence appends, block compression and digest output
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_cnt        = r_cnt;
        n_fill       = r_fill;
        n_blk        = r_blk;
        w_bram_we    = 1'b0;
        w_bram_re    = 1'b0;
        w_cram_we    = 1'b0;
        w_cram_re    = 1'b0;
        w_cram_clear = 1'b0;
        w_ctl        = '0;
        case (r_state)
            sha1mh_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_cnt = '0;
                    if (!i_command) begin
                        w_bram_we = 1'b1;
                        n_fill    = r_fill + 6'd1;
                        if (r_fill == sha1mh_pkg::LAST_FILL) begin
                            n_mode  = sha1mh_pkg::MODE_FULL;
                            n_state = sha1mh_pkg::ST_LOAD;
                        end
                    end else begin
                        n_mode  = sha1mh_pkg::MODE_TAIL;
                        n_state = sha1mh_pkg::ST_LOAD;
                    end
                end
            end
            sha1mh_pkg::ST_LOAD: begin
                w_bram_re    = (r_cnt < sha1mh_pkg::LOAD_END);
                w_cram_re    = (r_cnt < sha1mh_pkg::CHAIN_WORDS);
                w_ctl.load_w = (r_cnt != 7'd0);
                w_ctl.load_h = (r_cnt != 7'd0) && (r_cnt <= sha1mh_pkg::CHAIN_WORDS);
                if (r_cnt == sha1mh_pkg::LOAD_END) begin
                    n_cnt   = '0;
                    n_state = sha1mh_pkg::ST_ROUND;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            sha1mh_pkg::ST_ROUND: begin
                w_ctl.step = 1'b1;
                if (r_cnt == sha1mh_pkg::LAST_ROUND) begin
                    n_cnt   = '0;
                    n_state = sha1mh_pkg::ST_UPDATE;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            sha1mh_pkg::ST_UPDATE: begin
                w_cram_re = (r_cnt < sha1mh_pkg::CHAIN_WORDS);
                w_cram_we = (r_cnt != 7'd0);
                if (r_cnt == sha1mh_pkg::CHAIN_WORDS) begin
                    n_cnt = '0;
                    if (r_mode == sha1mh_pkg::MODE_FULL) begin
                        n_blk   = r_blk + 55'd1;
                        n_state = sha1mh_pkg::ST_IDLE;
                    end else if (r_mode == sha1mh_pkg::MODE_TAIL
                                 && r_fill >= sha1mh_pkg::LEN_START) begin
                        n_mode  = sha1mh_pkg::MODE_LENGTH;
                        n_state = sha1mh_pkg::ST_LOAD;
                    end else begin
                        n_state = sha1mh_pkg::ST_FETCH;
                    end
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            sha1mh_pkg::ST_FETCH: begin
                w_cram_re = 1'b1;
                n_state   = sha1mh_pkg::ST_SHOW;
            end
            sha1mh_pkg::ST_SHOW: begin
                if (i_out_ready) begin
                    if (r_cnt == sha1mh_pkg::LAST_DIGEST) begin
                        w_cram_clear = 1'b1;
                        n_fill       = '0;
                        n_blk        = '0;
                        n_cnt        = '0;
                        n_state      = sha1mh_pkg::ST_IDLE;
                    end else begin
                        n_cnt   = r_cnt + 7'd1;
                        n_state = sha1mh_pkg::ST_FETCH;
                    end
                end
            end
            default: begin
                n_state = sha1mh_pkg::ST_IDLE;
            end
        endcase
    end

    // Drive ports; the chain read register holds the digest word during stalls
    assign w_out_word       = w_cram_rd;
    assign o_in_ready       = (r_state == sha1mh_pkg::ST_IDLE);
    assign o_out_valid      = (r_state == sha1mh_pkg::ST_SHOW);
    assign o_digest_byte    = w_out_word[~r_cnt[1:0]];
    assign o_last_of_digest = (r_cnt == sha1mh_pkg::LAST_DIGEST);

endmodule

@@ src/sha1mh_block_ram.sv @@
// Message block buffer: 16 words of 32 bits, byte-lane write, registered read.
// Depends on sha1mh_pkg for the word types.
`timescale 1ns / 1ps

module sha1mh_block_ram (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [3:0]         i_wr_addr,
    input  logic [1:0]         i_wr_lane,
    input  logic [7:0]         i_wr_byte,
    input  logic               i_rd_en,
    input  logic [3:0]         i_rd_addr,
    output sha1mh_pkg::t_word  o_rd_data
);

    sha1mh_pkg::t_word_bytes r_mem [16];
    sha1mh_pkg::t_word       r_rd_data;

    // Write one byte; lane 0 is the most significant byte of the word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr][~i_wr_lane] <= i_wr_byte;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/sha1mh_chain_ram.sv @@
// Chaining word store: 5 words of 32 bits with per-entry valid bits.
// An entry that is not valid reads as its initial SHA-1 value (sha1mh_pkg).
`timescale 1ns / 1ps

module sha1mh_chain_ram (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clear,
    input  logic               i_wr_en,
    input  logic [2:0]         i_wr_addr,
    input  sha1mh_pkg::t_word  i_wr_data,
    input  logic               i_rd_en,
    input  logic [2:0]         i_rd_addr,
    output sha1mh_pkg::t_word  o_rd_data
);

    sha1mh_pkg::t_word r_mem [5];
    logic [4:0]        r_valid;
    sha1mh_pkg::t_word r_rd_data;

    // Track written entries; clear returns all entries to initial values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read with fallback to the initial value
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr]
                                            : sha1mh_pkg::H_INIT[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/sha1mh_round_core.sv @@
// SHA-1 round datapath: 16-word schedule shift line and working words a..e.
// Depends on sha1mh_pkg for types and the round functions.
`timescale 1ns / 1ps

module sha1mh_round_core (
    input  logic                    i_clk,
    input  sha1mh_pkg::t_core_ctl   i_ctl,
    input  logic [6:0]              i_rnd,
    input  sha1mh_pkg::t_word       i_w_word,
    input  sha1mh_pkg::t_word       i_h_word,
    output sha1mh_pkg::t_hash_state o_state
);

    logic [15:0][31:0]       r_w;
    sha1mh_pkg::t_hash_state r_st;

    sha1mh_pkg::t_word w_sum;
    sha1mh_pkg::t_word w_mix;
    sha1mh_pkg::t_word w_next;

    // One round: new a from rotated a, round function, e, constant and W
    always_comb begin
        w_sum = {r_st[0][26:0], r_st[0][31:27]}
              + sha1mh_pkg::round_f(i_rnd, r_st[1], r_st[2], r_st[3])
              + r_st[4]
              + sha1mh_pkg::round_k(i_rnd)
              + r_w[0];
        w_mix  = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_next = {w_mix[30:0], w_mix[31]};
    end

    // Schedule: shift in loaded words, or extend by one word each round
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_w) begin
            r_w <= {i_w_word, r_w[15:1]};
        end else if (i_ctl.step) begin
            r_w <= {w_next, r_w[15:1]};
        end
    end

    // Working words: shift in chaining words, or advance one round
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_h) begin
            r_st <= {i_h_word, r_st[4:1]};
        end else if (i_ctl.step) begin
            r_st[0] <= w_sum;
            r_st[1] <= r_st[0];
            r_st[2] <= {r_st[1][1:0], r_st[1][31:2]};
            r_st[3] <= r_st[2];
            r_st[4] <= r_st[3];
        end
    end

    assign o_state = r_st;

endmodule

@@ src/sha1mh_checker.sv @@
// Port-level checker for the SHA-1 message hasher, bound to the top level.
// Uses the assertion macros of sha1_message_hasher_assert.svh.
`timescale 1ns / 1ps
`include "sha1_message_hasher_assert.svh"

module sha1mh_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_digest_byte,
    input logic       o_last_of_digest
);

    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_last_acc;
    logic       w_out_stall;
    logic [8:0] w_out_pay;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;
    assign w_last_acc  = w_out_acc && o_last_of_digest;
    assign w_out_stall = o_out_valid && !i_out_ready;
    assign w_out_pay   = {o_digest_byte, o_last_of_digest};

    // No request is taken while a digest byte is on offer
    `SHA1MH_NEVER(a_no_accept_during_digest, o_out_valid && o_in_ready, "request in digest")

    // Any accepted request is followed by a cycle without output
    `SHA1MH_NEXT(a_quiet_after_request, w_in_acc, !o_out_valid, "output right after a request")

    // The final digest byte ends the output run
    `SHA1MH_NEXT(a_digest_ends, w_last_acc, !o_out_valid && o_in_ready, "digest did not end")

    // A stalled digest byte holds
    `SHA1MH_NEXT(a_stall_holds, w_out_stall, o_out_valid && $stable(w_out_pay), "stall changed")

endmodule

bind sha1_message_hasher sha1mh_checker u_sha1mh_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for sha1_message_hasher: random byte messages, SHA-1 predicted
// in place, digest bytes compared in order. Depends only on the sha1_message_hasher RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int TOTAL_ITEMS   = 310;
    localparam int TAIL_ITEMS    = 40;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AFTER    = 8;
    localparam int DRAIN_CYCLES  = 250;
    localparam int STUCK_LIMIT   = 4000;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [31:0] K_00_19  = 32'h5A827999;
    localparam logic [31:0] K_20_39  = 32'h6ED9EBA1;
    localparam logic [31:0] K_40_59  = 32'h8F1BBCDC;
    localparam logic [31:0] K_60_79  = 32'hCA62C1D6;
    localparam logic [31:0] IV_0     = 32'h67452301;
    localparam logic [31:0] IV_1     = 32'hEFCDAB89;
    localparam logic [31:0] IV_2     = 32'h98BADCFE;
    localparam logic [31:0] IV_3     = 32'h10325476;
    localparam logic [31:0] IV_4     = 32'hC3D2E1F0;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } t_hash_request;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_digest_entry;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       i_command = CMD_APPEND;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_digest_byte;
    logic       o_last_of_digest;

    t_hash_request request_queue[$];
    t_digest_entry digest_queue[$];
    logic          calm_tail = 1'b0;
    int            error_count = 0;
    int            stuck_cycles = 0;

    // Predictor state: chaining words, block buffer, fill level, bits in done blocks
    logic [31:0] hash_words [0:4];
    logic [7:0]  msg_block [0:63];
    logic [5:0]  fill_level;
    logic [63:0] bits_done;

    sha1_message_hasher uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_digest_byte   (o_digest_byte),
        .o_last_of_digest(o_last_of_digest)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at %0t: %s got %02h expected %02h",
                 $realtime, field, got, want);
        error_count++;
    endtask

    task automatic sha1_restart();
        hash_words[0] = IV_0;
        hash_words[1] = IV_1;
        hash_words[2] = IV_2;
        hash_words[3] = IV_3;
        hash_words[4] = IV_4;
        fill_level = 6'd0;
        bits_done = 64'd0;
    endtask

    // Run the 80 rounds over the buffered block into the chaining words
    task automatic sha1_compress();
        logic [31:0] w [0:79];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++) begin
            w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
        end
        for (int r = 16; r < 80; r++) begin
            t = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
            w[r] = {t[30:0], t[31]};
        end
        a = hash_words[0];
        b = hash_words[1];
        c = hash_words[2];
        d = hash_words[3];
        e = hash_words[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_00_19;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_20_39;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_40_59;
            end else begin
                f = b ^ c ^ d;
                k = K_60_79;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        hash_words[0] = hash_words[0] + a;
        hash_words[1] = hash_words[1] + b;
        hash_words[2] = hash_words[2] + c;
        hash_words[3] = hash_words[3] + d;
        hash_words[4] = hash_words[4] + e;
    endtask

    // Absorb one accepted request; a finish pads, compresses and queues the digest
    task automatic sha1_absorb(input logic cmd, input logic [7:0] data);
        int            pos;
        logic [63:0]   total;
        t_digest_entry ent;
        if (cmd == CMD_APPEND) begin
            msg_block[fill_level] = data;
            fill_level = fill_level + 6'd1;
            if (fill_level == 6'd0) begin
                sha1_compress();
                bits_done = bits_done + 64'd512;
            end
        end else begin
            pos = fill_level;
            total = bits_done + pos * 8;
            msg_block[pos] = PAD_BYTE;
            pos++;
            // no room for the length: pad out and spend an extra block
            if (pos > 56) begin
                while (pos < 64) begin
                    msg_block[pos] = 8'h00;
                    pos++;
                end
                sha1_compress();
                pos = 0;
            end
            while (pos < 56) begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            for (int n = 0; n < 8; n++) begin
                msg_block[56+n] = total[63-8*n -: 8];
            end
            sha1_compress();
            for (int n = 0; n < 20; n++) begin
                ent.value = hash_words[n/4][31-8*(n%4) -: 8];
                ent.last = (n == 19);
                digest_queue.push_back(ent);
            end
            sha1_restart();
        end
    endtask

    task automatic queue_request(input logic cmd, input logic [7:0] data);
        t_hash_request req;
        req.cmd = cmd;
        req.data = data;
        request_queue.push_back(req);
    endtask

    task automatic queue_message(input int len);
        for (int n = 0; n < len; n++) begin
            queue_request(CMD_APPEND, 8'($urandom_range(0, 255)));
        end
        queue_request(CMD_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // Request driver: predict on acceptance, then offer the next request or idle
    always @(posedge i_clk) begin : drive_requests
        int            send_gap;
        int            quiet_left;
        logic          next_valid;
        t_hash_request req;
        if (!i_rst_n) begin
            send_gap = 0;
            quiet_left = 0;
            sha1_restart();
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                sha1_absorb(i_command, i_data_byte);
                next_valid = 1'b0;
            end
            if (quiet_left > 0) begin
                quiet_left--;
            end else if ($urandom_range(0, 49) == 0) begin
                quiet_left = $urandom_range(30, 120);
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (request_queue.size() > 0) begin
                    if (!calm_tail && quiet_left == 0 && $urandom_range(0, 4) == 0) begin
                        send_gap = $urandom_range(0, 13);
                    end else begin
                        req = request_queue.pop_front();
                        i_command <= req.cmd;
                        i_data_byte <= req.data;
                        next_valid = 1'b1;
                    end
                end
            end
            i_in_valid <= next_valid;
            calm_tail <= (request_queue.size() < TAIL_ITEMS);
        end
    end

    // Digest monitor: check each accepted byte, then pick the next ready level
    always @(posedge i_clk) begin : check_digest
        int            stall_left;
        int            quiet_left;
        int            hold_left;
        int            digests_done;
        logic          hold_done;
        logic          next_ready;
        t_digest_entry want;
        if (!i_rst_n) begin
            stall_left = 0;
            quiet_left = 0;
            hold_left = 0;
            digests_done = 0;
            hold_done = 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (digest_queue.size() == 0) begin
                    report_mismatch("unexpected digest_byte", o_digest_byte, 8'h00);
                end else begin
                    want = digest_queue.pop_front();
                    if (o_digest_byte !== want.value) begin
                        report_mismatch("digest_byte", o_digest_byte, want.value);
                    end
                    if (o_last_of_digest !== want.last) begin
                        report_mismatch("last_of_digest", {7'd0, o_last_of_digest},
                                        {7'd0, want.last});
                    end
                    if (want.last) begin
                        digests_done++;
                    end
                end
            end
            if (quiet_left > 0) begin
                quiet_left--;
            end else if ($urandom_range(0, 49) == 0) begin
                quiet_left = $urandom_range(30, 120);
            end
            // hold off once for a long stretch so the block backs up into its input
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (!hold_done && digests_done == HOLD_AFTER && o_out_valid) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                next_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else if (!calm_tail && quiet_left == 0 && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 13);
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            i_out_ready <= next_ready;
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stuck_cycles <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : run_sequence
        int msg_len;
        int room;
        // empty message, twice back to back
        queue_request(CMD_FINISH, 8'h00);
        queue_request(CMD_FINISH, 8'hFF);
        // "abc"
        queue_request(CMD_APPEND, 8'h61);
        queue_request(CMD_APPEND, 8'h62);
        queue_request(CMD_APPEND, 8'h63);
        queue_request(CMD_FINISH, 8'h00);
        // data byte extremes
        queue_request(CMD_APPEND, 8'h00);
        queue_request(CMD_APPEND, 8'hFF);
        queue_request(CMD_APPEND, 8'h80);
        queue_request(CMD_APPEND, 8'h7F);
        queue_request(CMD_APPEND, 8'h01);
        queue_request(CMD_FINISH, 8'hFF);
        queue_request(CMD_APPEND, 8'hFF);
        queue_request(CMD_FINISH, 8'h00);
        queue_request(CMD_APPEND, 8'h00);
        queue_request(CMD_FINISH, 8'h00);

        // length boundaries: last single-block pad, extra pad block, exact block
        queue_message(55);
        queue_message(56);
        queue_message(63);
        queue_message(64);
        while (request_queue.size() < TOTAL_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 5))
                    0: msg_len = 55;
                    1: msg_len = 56;
                    2: msg_len = 57;
                    3: msg_len = 63;
                    4: msg_len = 65;
                    default: msg_len = 119;
                endcase
            end else begin
                msg_len = $urandom_range(0, 30);
            end
            // keep the last message inside the request budget
            room = TOTAL_ITEMS - request_queue.size();
            if (msg_len >= room) begin
                msg_len = room - 1;
            end
            queue_message(msg_len);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every request to go in and every digest byte to come out
        do begin
            @(negedge i_clk);
        end while (request_queue.size() != 0 || i_in_valid || digest_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
